### sv/hrp_pkg.sv
// Package for the HTTP request header parser: phase, mode and status codes,
// plus the keyword character tables. No dependencies.
package hrp_pkg;

   typedef enum logic [3:0] {
      PH_METHOD   = 4'd0,
      PH_URL_SKIP = 4'd1,
      PH_URL      = 4'd2,
      PH_VER_SKIP = 4'd3,
      PH_VER      = 4'd4,
      PH_HEADER   = 4'd5,
      PH_BODY     = 4'd6,
      PH_DONE     = 4'd7,
      PH_BAD      = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      UM_PREFIX = 2'd0,
      UM_HOST   = 2'd1,
      UM_PATH   = 2'd2
   } url_mode_type;

   typedef enum logic [2:0] {
      HV_NAME       = 3'd0,
      HV_IGNORE     = 3'd1,
      HV_CONN_SKIP  = 3'd2,
      HV_CONN_MATCH = 3'd3,
      HV_LEN_SKIP   = 3'd4,
      HV_LEN_DIGITS = 3'd5,
      HV_HOST_SKIP  = 3'd6,
      HV_HOST_VALUE = 3'd7
   } hdr_mode_type;

   localparam logic [1:0] ST_MORE = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   localparam logic [3:0] GET_LEN    = 4'd3;
   localparam logic [3:0] VER_LEN    = 4'd8;
   localparam logic [3:0] PREFIX_LEN = 4'd7;
   localparam logic [3:0] KA_LEN     = 4'd10;

   function automatic logic [7:0] low_case(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == " ") || (c == 8'h09);
   endfunction

   function automatic logic [7:0] get_char(input logic [3:0] p);
      unique case (p)
         4'd0:    return "g";
         4'd1:    return "e";
         4'd2:    return "t";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ver_char(input logic [3:0] p);
      unique case (p)
         4'd0:    return "h";
         4'd1:    return "t";
         4'd2:    return "t";
         4'd3:    return "p";
         4'd4:    return "/";
         4'd5:    return "1";
         4'd6:    return ".";
         4'd7:    return "1";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] prefix_char(input logic [3:0] p);
      unique case (p)
         4'd0:    return "h";
         4'd1:    return "t";
         4'd2:    return "t";
         4'd3:    return "p";
         4'd4:    return ":";
         4'd5:    return "/";
         4'd6:    return "/";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] ka_char(input logic [3:0] p);
      unique case (p)
         4'd0:    return "k";
         4'd1:    return "e";
         4'd2:    return "e";
         4'd3:    return "p";
         4'd4:    return "-";
         4'd5:    return "a";
         4'd6:    return "l";
         4'd7:    return "i";
         4'd8:    return "v";
         4'd9:    return "e";
         default: return 8'h00;
      endcase
   endfunction

   // header keywords: 0 connection:, 1 content-length:, 2 host:
   function automatic logic [3:0] kw_len(input logic [1:0] k);
      unique case (k)
         2'd0:    return 4'd11;
         2'd1:    return 4'd15;
         default: return 4'd5;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] p);
      logic [7:0] c;
      c = 8'h00;
      unique case (k)
         2'd0: begin
            unique case (p)
               4'd0: c = "c"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "n";
               4'd4: c = "e"; 4'd5: c = "c"; 4'd6: c = "t"; 4'd7: c = "i";
               4'd8: c = "o"; 4'd9: c = "n"; 4'd10: c = ":";
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            unique case (p)
               4'd0: c = "c"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "t";
               4'd4: c = "e"; 4'd5: c = "n"; 4'd6: c = "t"; 4'd7: c = "-";
               4'd8: c = "l"; 4'd9: c = "e"; 4'd10: c = "n"; 4'd11: c = "g";
               4'd12: c = "t"; 4'd13: c = "h"; 4'd14: c = ":";
               default: c = 8'h00;
            endcase
         end
         default: begin
            unique case (p)
               4'd0: c = "h"; 4'd1: c = "o"; 4'd2: c = "s"; 4'd3: c = "t";
               4'd4: c = ":";
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic hdr_mode_type kw_mode(input logic [1:0] k);
      unique case (k)
         2'd0:    return HV_CONN_SKIP;
         2'd1:    return HV_LEN_SKIP;
         default: return HV_HOST_SKIP;
      endcase
   endfunction

endpackage

### sv/hrp_if.sv
// Valid/ready stream interfaces for request bytes and parse results.
// Depends on nothing.
interface hrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_request;
   modport source (output valid, data_byte, new_request, input ready);
   modport sink   (input valid, data_byte, new_request, output ready);
endinterface

interface hrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        keep_alive;
   logic [31:0] body_length;
   logic        url_byte;
   logic        host_byte;
   logic        body_byte;
   modport source (output valid, status, keep_alive, body_length, url_byte,
                   host_byte, body_byte, input ready);
   modport sink   (input valid, status, keep_alive, body_length, url_byte,
                   host_byte, body_byte, output ready);
endinterface

### sv/http_request_header_parser.sv
// HTTP/1.1 request header parser, top level.
// Uses hrp_pkg and the stream interfaces in hrp_if.sv.
// Usage:
//  - req_bus carries one received request byte per transfer, with new_request
//    set on the first byte of a new request to clear all parser state.
//  - rsp_bus returns exactly one result per request byte: status (more /
//    complete / bad), the keep-alive flag, the content length and per-byte
//    marks for URL path, Host value and body bytes.
//  - The result is registered: a byte taken at an edge has its result valid
//    after that edge. Throughput is one byte per cycle while rsp_bus is not
//    stalled; the whole per-byte step (line splitting, keyword match, decimal
//    accumulate) sits between the request handshake and the result register.
//  - A CR is held as pending for one byte; when the next byte is not LF the
//    CR is parsed as line data together with that byte in the same cycle.
//  - Reset clears the parser to the start of a request line and empties the
//    result register. No clearing pass is needed.
//  - When rsp_bus stalls with a result held, req_bus.ready drops; a byte is
//    taken again in the same cycle the held result is taken.
//  - After complete or bad, bytes are still answered with the same status
//    until new_request.
module http_request_header_parser #(
   parameter int LENGTH_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   hrp_req_if.sink   req_bus,
   hrp_rsp_if.source rsp_bus
);

   localparam int AW = LENGTH_BITS;

   typedef struct packed {
      hrp_pkg::phase_type    phase;
      logic [3:0]            mpos;
      logic [2:0]            live;
      hrp_pkg::url_mode_type umode;
      logic                  cr_pend;
      logic                  line_empty;
      hrp_pkg::hdr_mode_type hmode;
      logic                  ka;
      logic [AW-1:0]         acc;
      logic [AW-1:0]         remain;
   } pstate_type;

   typedef struct packed {
      pstate_type s;
      logic       mark_url;
      logic       mark_host;
   } feed_out_type;

   // ---------------------------------------------------------------
   // helpers
   // ---------------------------------------------------------------
   function automatic pstate_type reset_state();
      pstate_type s;
      s.phase      = hrp_pkg::PH_METHOD;
      s.mpos       = '0;
      s.live       = 3'b111;
      s.umode      = hrp_pkg::UM_PREFIX;
      s.cr_pend    = 1'b0;
      s.line_empty = 1'b1;
      s.hmode      = hrp_pkg::HV_NAME;
      s.ka         = 1'b0;
      s.acc        = '0;
      s.remain     = '0;
      return s;
   endfunction

   // acc*10 + d, saturating at all ones
   function automatic logic [AW-1:0] add_digit(input logic [AW-1:0] acc,
                                                input logic [7:0] c);
      logic [AW+3:0] sum;
      sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (AW+4)'(c - "0");
      return (sum[AW+3:AW] != 4'd0) ? {AW{1'b1}} : sum[AW-1:0];
   endfunction

   function automatic feed_out_type feed(input pstate_type si, input logic [7:0] c,
                                         input logic cur);
      feed_out_type r;
      logic [7:0]   lc;
      logic [2:0]   lv;
      logic [3:0]   p;
      logic         hit;
      r = '{s: si, mark_url: 1'b0, mark_host: 1'b0};
      lc = hrp_pkg::low_case(c);
      lv = si.live;
      p = si.mpos;
      hit = 1'b0;
      r.s.line_empty = 1'b0;
      unique case (si.phase)
         hrp_pkg::PH_METHOD: begin
            if (hrp_pkg::is_blank(c)) begin
               if (si.mpos == hrp_pkg::GET_LEN) begin
                  r.s.phase = hrp_pkg::PH_URL_SKIP;
                  r.s.mpos = '0;
               end else begin
                  r.s.phase = hrp_pkg::PH_BAD;
               end
            end else if (si.mpos < hrp_pkg::GET_LEN && lc == hrp_pkg::get_char(si.mpos)) begin
               r.s.mpos = si.mpos + 4'd1;
            end else begin
               r.s.phase = hrp_pkg::PH_BAD;
            end
         end
         hrp_pkg::PH_URL_SKIP, hrp_pkg::PH_URL: begin
            if (si.phase == hrp_pkg::PH_URL_SKIP && hrp_pkg::is_blank(c)) begin
               // stay
            end else begin
               if (si.phase == hrp_pkg::PH_URL_SKIP) begin
                  r.s.phase = hrp_pkg::PH_URL;
                  r.s.mpos = '0;
                  r.s.umode = hrp_pkg::UM_PREFIX;
               end
               if (hrp_pkg::is_blank(c)) begin
                  r.s.phase = (r.s.umode == hrp_pkg::UM_PATH) ? hrp_pkg::PH_VER_SKIP
                                                              : hrp_pkg::PH_BAD;
               end else if (r.s.umode == hrp_pkg::UM_PREFIX) begin
                  if (r.s.mpos == 4'd0 && c == "/") begin
                     r.s.umode = hrp_pkg::UM_PATH;
                     r.mark_url = cur;
                  end else if (r.s.mpos < hrp_pkg::PREFIX_LEN &&
                               lc == hrp_pkg::prefix_char(r.s.mpos)) begin
                     r.s.mpos = r.s.mpos + 4'd1;
                     if (r.s.mpos == hrp_pkg::PREFIX_LEN) r.s.umode = hrp_pkg::UM_HOST;
                  end else begin
                     r.s.phase = hrp_pkg::PH_BAD;
                  end
               end else if (r.s.umode == hrp_pkg::UM_HOST) begin
                  if (c == "/") begin
                     r.s.umode = hrp_pkg::UM_PATH;
                     r.mark_url = cur;
                  end
               end else begin
                  r.mark_url = cur;
               end
            end
         end
         hrp_pkg::PH_VER_SKIP, hrp_pkg::PH_VER: begin
            if (si.phase == hrp_pkg::PH_VER_SKIP && hrp_pkg::is_blank(c)) begin
               // stay
            end else begin
               if (si.phase == hrp_pkg::PH_VER_SKIP) begin
                  r.s.phase = hrp_pkg::PH_VER;
                  r.s.mpos = '0;
               end
               if (r.s.mpos < hrp_pkg::VER_LEN && lc == hrp_pkg::ver_char(r.s.mpos))
                  r.s.mpos = r.s.mpos + 4'd1;
               else
                  r.s.phase = hrp_pkg::PH_BAD;
            end
         end
         hrp_pkg::PH_HEADER: begin
            unique case (si.hmode)
               hrp_pkg::HV_NAME: begin
                  for (int k = 0; k < 3; k++) begin
                     if (lv[k] && !(p < hrp_pkg::kw_len(2'(k)) &&
                                   lc == hrp_pkg::kw_char(2'(k), p)))
                        lv[k] = 1'b0;
                  end
                  r.s.live = lv;
                  r.s.mpos = p + 4'd1;
                  if (lv == 3'b000) begin
                     r.s.hmode = hrp_pkg::HV_IGNORE;
                  end else begin
                     for (int k = 0; k < 3; k++) begin
                        if (!hit && lv[k] && (p + 4'd1) == hrp_pkg::kw_len(2'(k))) begin
                           hit = 1'b1;
                           r.s.hmode = hrp_pkg::kw_mode(2'(k));
                           r.s.mpos = '0;
                           if (k == 1) r.s.acc = '0;
                        end
                     end
                  end
               end
               hrp_pkg::HV_CONN_SKIP, hrp_pkg::HV_CONN_MATCH: begin
                  if (si.hmode == hrp_pkg::HV_CONN_SKIP && hrp_pkg::is_blank(c)) begin
                     // stay
                  end else begin
                     if (si.hmode == hrp_pkg::HV_CONN_SKIP) begin
                        r.s.hmode = hrp_pkg::HV_CONN_MATCH;
                        r.s.mpos = '0;
                     end
                     if (r.s.mpos < hrp_pkg::KA_LEN && lc == hrp_pkg::ka_char(r.s.mpos))
                        r.s.mpos = r.s.mpos + 4'd1;
                     else
                        r.s.hmode = hrp_pkg::HV_IGNORE;
                  end
               end
               hrp_pkg::HV_LEN_SKIP: begin
                  if (hrp_pkg::is_blank(c) || c == 8'h0b || c == 8'h0c ||
                      c == hrp_pkg::CH_CR) begin
                     // skip leading blanks
                  end else if (c == "+") begin
                     r.s.hmode = hrp_pkg::HV_LEN_DIGITS;
                  end else if (c >= "0" && c <= "9") begin
                     r.s.hmode = hrp_pkg::HV_LEN_DIGITS;
                     r.s.acc = add_digit(si.acc, c);
                  end else begin
                     r.s.hmode = hrp_pkg::HV_IGNORE;
                  end
               end
               hrp_pkg::HV_LEN_DIGITS: begin
                  if (c >= "0" && c <= "9") r.s.acc = add_digit(si.acc, c);
                  else r.s.hmode = hrp_pkg::HV_IGNORE;
               end
               hrp_pkg::HV_HOST_SKIP: begin
                  if (!hrp_pkg::is_blank(c)) begin
                     r.s.hmode = hrp_pkg::HV_HOST_VALUE;
                     r.mark_host = cur;
                  end
               end
               hrp_pkg::HV_HOST_VALUE: r.mark_host = cur;
               default: ;
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic pstate_type end_line(input pstate_type si);
      pstate_type s;
      s = si;
      if (si.phase == hrp_pkg::PH_VER && si.mpos == hrp_pkg::VER_LEN) begin
         s.phase = hrp_pkg::PH_HEADER;
      end else if (si.phase == hrp_pkg::PH_HEADER) begin
         if (si.line_empty) begin
            if (si.acc != '0) begin
               s.remain = si.acc;
               s.phase = hrp_pkg::PH_BODY;
            end else begin
               s.phase = hrp_pkg::PH_DONE;
            end
         end else if (si.hmode == hrp_pkg::HV_CONN_MATCH && si.mpos == hrp_pkg::KA_LEN) begin
            s.ka = 1'b1;
         end
      end else begin
         s.phase = hrp_pkg::PH_BAD;
      end
      s.mpos = '0;
      s.live = 3'b111;
      s.hmode = hrp_pkg::HV_NAME;
      s.line_empty = 1'b1;
      return s;
   endfunction

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   pstate_type  st_ff, st_in;
   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic        ka_ff;
   logic [31:0] clen_ff, clen_in;
   logic        url_ff, url_in, host_ff, host_in, body_ff, body_in;
   logic        accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;

   // one byte step
   always_comb begin
      pstate_type   s;
      feed_out_type f;
      logic         handled;
      logic [63:0]  wide;
      logic [7:0]   b;
      b = req_bus.data_byte;
      s = req_bus.new_request ? reset_state() : st_ff;
      url_in = 1'b0;
      host_in = 1'b0;
      body_in = 1'b0;
      handled = 1'b0;
      f = '{s: s, mark_url: 1'b0, mark_host: 1'b0};
      if (s.phase == hrp_pkg::PH_BODY) begin
         body_in = 1'b1;
         if (s.remain != '0) s.remain = s.remain - AW'(1);
         if (s.remain == '0) s.phase = hrp_pkg::PH_DONE;
      end else if (s.phase < hrp_pkg::PH_BODY) begin
         if (s.cr_pend) begin
            s.cr_pend = 1'b0;
            if (b == hrp_pkg::CH_LF) begin
               s = end_line(s);
               handled = 1'b1;
            end else begin
               // pending CR turns out to be line data
               f = feed(s, hrp_pkg::CH_CR, 1'b0);
               s = f.s;
               if (s.phase == hrp_pkg::PH_BAD) handled = 1'b1;
            end
         end
         if (!handled) begin
            if (b == hrp_pkg::CH_CR) begin
               s.cr_pend = 1'b1;
            end else if (b == hrp_pkg::CH_LF) begin
               s.phase = hrp_pkg::PH_BAD;
            end else begin
               f = feed(s, b, 1'b1);
               s = f.s;
               url_in = f.mark_url;
               host_in = f.mark_host;
            end
         end
      end else if (s.phase != hrp_pkg::PH_DONE) begin
         s.phase = hrp_pkg::PH_BAD;
      end
      st_in = s;
      status_in = (s.phase == hrp_pkg::PH_DONE) ? hrp_pkg::ST_DONE :
                  (s.phase == hrp_pkg::PH_BAD)  ? hrp_pkg::ST_BAD  : hrp_pkg::ST_MORE;
      wide = 64'(s.acc);
      clen_in = (wide[63:32] != 32'd0) ? 32'hffff_ffff : wide[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= reset_state();
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            st_ff <= st_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         ka_ff <= st_in.ka;
         clen_ff <= clen_in;
         url_ff <= url_in;
         host_ff <= host_in;
         body_ff <= body_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.keep_alive = ka_ff;
   assign rsp_bus.body_length = clen_ff;
   assign rsp_bus.url_byte = url_ff;
   assign rsp_bus.host_byte = host_ff;
   assign rsp_bus.body_byte = body_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_marks_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((url_ff + host_ff + body_ff) <= 2'd1))
      else $error("more than one byte mark set");

   a_url_only_parsing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (url_ff || host_ff)) |-> status_ff == hrp_pkg::ST_MORE)
      else $error("URL or Host mark with final status");

   a_body_not_bad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && body_ff) |-> status_ff != hrp_pkg::ST_BAD)
      else $error("body byte flagged bad");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> $stable(st_ff))
      else $error("parser advanced while result held");

endmodule
